// ===== hdl/cti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cti_pkg
// Shared types and constants for the cone track isolation block.
// ----------------------------------------------------------------------------
package cti_pkg;

	// item kinds
	localparam logic [1:0] KIND_CAND  = 2'd0;
	localparam logic [1:0] KIND_MUON0 = 2'd1;
	localparam logic [1:0] KIND_MUON1 = 2'd2;
	localparam logic [1:0] KIND_TRACK = 2'd3;

	// configuration register indexes
	localparam logic CFG_CONE_RADIUS  = 1'b0;
	localparam logic CFG_MIN_TRACK_PT = 1'b1;

	localparam logic [11:0] CONE_RADIUS_RESET  = 12'd307;
	localparam logic [15:0] MIN_TRACK_PT_RESET = 16'd64;

	// deltaR < 0.01 with d2 in 1/1024^2 units: d2 * 10000 < 2^20, i.e. d2 <= 104
	localparam logic [28:0] MUON_VETO_D2_MAX = 29'd104;

	localparam logic [23:0] SUM_MAX = 24'hFFFFFF;

	// queue between classifier and accumulator
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] pt;
		logic        keep;
		logic        last;
	} entry_t;

	typedef struct packed {
		logic              valid;
		logic [QCNT_W-1:0] count;
	} queue_status_t;

endpackage

// ===== hdl/cti_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cti_front
// Accepts words, keeps candidate and muon directions, and classifies tracks
// through a two-stage geometry pipeline into the queue.
// ----------------------------------------------------------------------------
module cti_front import cti_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    kind,
	input  logic signed [13:0] eta,
	input  logic signed [12:0] phi,
	input  logic [15:0]   pt,
	input  logic          charged,
	input  logic          last,
	input  logic [11:0]   cone_radius,
	input  logic [15:0]   min_track_pt,
	input  queue_status_t q_status,
	output logic          push,
	output entry_t        push_entry
);

	function automatic logic signed [13:0] wrap_phi(input logic signed [14:0] d);
		logic signed [14:0] x;
		x = d;
		for (int k = 0; k < 2; k++) begin
			if (x > 15'sd3217) x = x - 15'sd6434;
			else if (x < -15'sd3217) x = x + 15'sd6434;
		end
		return x[13:0];
	endfunction

	logic signed [13:0] cand_eta_q;
	logic signed [12:0] cand_phi_q;
	logic signed [13:0] muon_eta_q [2];
	logic signed [12:0] muon_phi_q [2];

	logic v_s1, v_s2;
	logic [1:0]  kind_s1, kind_s2;
	logic [15:0] pt_s1, pt_s2;
	logic        last_s1, last_s2;
	logic        basic_s1, basic_s2;
	logic signed [14:0] de_s1 [3];
	logic signed [13:0] dp_s1 [3];
	logic [28:0] d2_s2 [3];

	logic accept;
	logic signed [13:0] ref_eta [3];
	logic signed [12:0] ref_phi [3];

	// reserve a queue slot for every word in flight
	assign in_ready = ({1'b0, q_status.count} + {3'b0, v_s1} + {3'b0, v_s2})
		< 4'(QUEUE_DEPTH);
	assign accept = in_valid && in_ready;

	assign ref_eta[0] = muon_eta_q[0];
	assign ref_eta[1] = muon_eta_q[1];
	assign ref_eta[2] = cand_eta_q;
	assign ref_phi[0] = muon_phi_q[0];
	assign ref_phi[1] = muon_phi_q[1];
	assign ref_phi[2] = cand_phi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_eta_q    <= '0;
			cand_phi_q    <= '0;
			muon_eta_q[0] <= '0;
			muon_eta_q[1] <= '0;
			muon_phi_q[0] <= '0;
			muon_phi_q[1] <= '0;
		end else if (accept) begin
			unique case (kind)
				KIND_CAND: begin
					cand_eta_q <= eta;
					cand_phi_q <= phi;
				end
				KIND_MUON0: begin
					muon_eta_q[0] <= eta;
					muon_phi_q[0] <= phi;
				end
				KIND_MUON1: begin
					muon_eta_q[1] <= eta;
					muon_phi_q[1] <= phi;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// stage 1: differences against the stored directions
	always_ff @(posedge clk) begin
		kind_s1  <= kind;
		pt_s1    <= pt;
		last_s1  <= last;
		basic_s1 <= charged && (pt >= min_track_pt);
		for (int i = 0; i < 3; i++) begin
			de_s1[i] <= 15'(eta) - 15'(ref_eta[i]);
			dp_s1[i] <= wrap_phi(15'(phi) - 15'(ref_phi[i]));
		end
	end

	// stage 2: squared distances
	always_ff @(posedge clk) begin
		kind_s2  <= kind_s1;
		pt_s2    <= pt_s1;
		last_s2  <= last_s1;
		basic_s2 <= basic_s1;
		for (int i = 0; i < 3; i++) begin
			d2_s2[i] <= 29'(30'(de_s1[i] * de_s1[i])) + 29'(28'(dp_s1[i] * dp_s1[i]));
		end
	end

	logic [23:0] r_sq;
	logic veto, outside;
	assign r_sq    = 12'(cone_radius) * 12'(cone_radius) + 24'd0;
	assign veto    = (d2_s2[0] <= MUON_VETO_D2_MAX) || (d2_s2[1] <= MUON_VETO_D2_MAX);
	assign outside = d2_s2[2] > {5'b0, r_sq};

	assign push            = v_s2;
	assign push_entry.kind = kind_s2;
	assign push_entry.pt   = pt_s2;
	assign push_entry.keep = basic_s2 && !veto && !outside;
	assign push_entry.last = last_s2;

endmodule

// ===== hdl/cti_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cti_queue
// Small FIFO of classified words between the front and the accumulator.
// ----------------------------------------------------------------------------
module cti_queue import cti_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  entry_t        push_entry,
	input  logic          pop,
	output entry_t        head,
	output queue_status_t status
);

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head         = mem_q[rd_q];
	assign status.valid = count_q != '0;
	assign status.count = count_q;

endmodule

// ===== hdl/cti_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cti_back
// Accumulates accepted track pt, and at the end of an event divides the
// candidate pt by the total with a restoring divider into the output register.
// ----------------------------------------------------------------------------
module cti_back import cti_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  queue_status_t q_status,
	input  entry_t        head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [16:0]   isolation,
	output logic [23:0]   summed_pt,
	output logic          zero_denominator
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_INIT = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]  state_q;
	logic [15:0] cand_pt_q;
	logic [23:0] sum_q;
	logic [32:0] rem_q;
	logic [40:0] dsh_q;
	logic [16:0] quo_q;
	logic [4:0]  cnt_q;
	logic        zero_q;
	logic        out_valid_q;
	logic [16:0] iso_q;
	logic [23:0] osum_q;
	logic        ozero_q;

	logic [24:0] den;
	logic [24:0] sum_add;
	logic        take_out;

	assign pop      = (state_q == ST_IDLE) && q_status.valid;
	assign den      = {9'b0, cand_pt_q} + {1'b0, sum_q};
	assign sum_add  = {1'b0, sum_q} + {9'b0, head.pt};
	assign take_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cand_pt_q <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.kind == KIND_CAND) begin
							cand_pt_q <= head.pt;
							sum_q     <= '0;
						end else if (head.kind == KIND_TRACK && head.keep) begin
							sum_q <= sum_add[24] ? SUM_MAX : sum_add[23:0];
						end
						if (head.last) state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					cnt_q   <= 5'd16;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (take_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// divider datapath: one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_INIT) begin
			rem_q  <= {1'b0, cand_pt_q, 16'h0} + {9'b0, den[24:1]};
			dsh_q  <= {den, 16'h0};
			zero_q <= den == '0;
		end else if (state_q == ST_DIV) begin
			if ({8'b0, rem_q} >= dsh_q) begin
				rem_q <= 33'({8'b0, rem_q} - dsh_q);
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				quo_q <= {quo_q[15:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_out) begin
			iso_q   <= zero_q ? '0 : quo_q;
			osum_q  <= sum_q;
			ozero_q <= zero_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign isolation        = iso_q;
	assign summed_pt        = osum_q;
	assign zero_denominator = ozero_q;

endmodule

// ===== hdl/cone_track_isolation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cone_track_isolation
// Relative track isolation of a candidate: sums the pt of tracks inside the
// cone, outside the muon veto, and returns cand_pt / (cand_pt + sum).
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  input    | in_valid / in_ready  | kind, eta, phi, pt, charged, last
//  output   | out_valid / out_ready| isolation, summed_pt, zero_denominator
//  config   | cfg_we               | cfg_index, cfg_data
//
//  Words without last are taken while the accumulator is idle; the geometry
//  runs two stages ahead of a four-entry queue. A word with last sends the
//  accumulator through the 17-step divider before it takes the next word.
//  Reset clears all stored directions, the sum and the queue.
//  The front keeps accepting while the divider runs or a result waits,
//  until the queue slots are all reserved.
//
module cone_track_isolation import cti_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic signed [13:0] eta,
	input  logic signed [12:0] phi,
	input  logic [15:0]        pt,
	input  logic               charged,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [16:0]        isolation,
	output logic [23:0]        summed_pt,
	output logic               zero_denominator,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	logic [11:0]   cone_radius_q;
	logic [15:0]   min_track_pt_q;
	queue_status_t q_status;
	entry_t        push_entry, head;
	logic          push, pop;

	// hold configuration; the user must make writes only while idle, the block has no check for it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cone_radius_q  <= CONE_RADIUS_RESET;
			min_track_pt_q <= MIN_TRACK_PT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CONE_RADIUS:  cone_radius_q  <= cfg_data[11:0];
				CFG_MIN_TRACK_PT: min_track_pt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify words and update directions
	cti_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.eta          (eta),
		.phi          (phi),
		.pt           (pt),
		.charged      (charged),
		.last         (last),
		.cone_radius  (cone_radius_q),
		.min_track_pt (min_track_pt_q),
		.q_status     (q_status),
		.push         (push),
		.push_entry   (push_entry)
	);

	// decouple classification from accumulation
	cti_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	// accumulate and divide
	cti_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_status         (q_status),
		.head             (head),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.isolation        (isolation),
		.summed_pt        (summed_pt),
		.zero_denominator (zero_denominator)
	);

endmodule

// ===== hdl/cti_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cti_checker
// Port-level checks on the result channel of the isolation block.
// ----------------------------------------------------------------------------
module cti_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [16:0] isolation,
	input logic [23:0] summed_pt,
	input logic        zero_denominator
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(isolation) && $stable(summed_pt))
		else $error("result changed while stalled");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_denominator |-> isolation == 17'd0 && summed_pt == 24'd0)
		else $error("zero denominator with nonzero fields");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zero_denominator && summed_pt == 24'd0 |-> isolation == 17'h10000)
		else $error("empty cone must give unit isolation");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> isolation <= 17'h10000)
		else $error("isolation above one");

endmodule

bind cone_track_isolation cti_checker u_chk (.*);
